[hw/rtl/llx_pkg.sv]
// Shared types, constants and helper functions of the lockstep link exchange block.
package llx_pkg;

  localparam int PAYLOAD_BITS = 10;
  localparam int GEN_BITS     = 3;
  localparam int WORD_BITS    = 16;
  localparam int BTN_BITS     = 10;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;

  localparam int MARK_SHIFT = PAYLOAD_BITS + GEN_BITS;
  localparam logic [WORD_BITS-1:0] MARK_MASK =
    WORD_BITS'((16'hFFFF >> MARK_SHIFT) << MARK_SHIFT);
  localparam logic [WORD_BITS-1:0] MARK_VALUE = 16'h8000;
  localparam logic [WORD_BITS-1:0] PAY_MASK = WORD_BITS'((32'd1 << PAYLOAD_BITS) - 1);

  localparam logic [15:0] TIMEOUT_RESET     = 16'd1638;
  localparam logic [9:0]  ELAPSED_MAX_RESET = 10'd15;

  typedef enum logic [1:0] {
    CMD_STEP = 2'd0,
    CMD_RECV = 2'd1,
    CMD_POLL = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_WAITING   = 2'd0,
    ST_STEP_DONE = 2'd1,
    ST_LINK_LOST = 2'd2,
    ST_TIMED_OUT = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TIMEOUT_TICKS = 1'd0,
    CFG_ELAPSED_MAX   = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [9:0]         buttons;
    logic signed [15:0] elapsed;
    logic [15:0]        word_a;
    logic [15:0]        word_b;
    logic               sio_error;
    logic               connected;
    logic               is_slave;
    logic               transfer_busy;
    logic [1:0]         player_id;
    logic [15:0]        timer_now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        send_valid;
    logic [15:0] send_word;
    logic        start_transfer;
    logic [9:0]  buttons_player0;
    logic [9:0]  buttons_player1;
    logic [9:0]  agreed_elapsed;
  } out_item_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [9:0]  elapsed_max;
  } cfg_t;

  typedef struct packed {
    logic [GEN_BITS-1:0]     generation;
    logic                    rx_ready;
    logic                    tx_pending;
    logic                    step_phase;
    logic                    have_previous;
    logic [WORD_BITS-1:0]    current_packet;
    logic [WORD_BITS-1:0]    previous_packet;
    logic [PAYLOAD_BITS-1:0] recv_p0;
    logic [PAYLOAD_BITS-1:0] recv_p1;
    logic [BTN_BITS-1:0]     agreed_p0;
    logic [BTN_BITS-1:0]     agreed_p1;
    logic [15:0]             wait_start;
    logic [9:0]              held_elapsed;
  } state_t;

  // True when the word carries the packet marker.
  function automatic logic mark_ok(input logic [WORD_BITS-1:0] w);
    return (w & MARK_MASK) == MARK_VALUE;
  endfunction

  // True when the word carries the marker and the given generation.
  function automatic logic word_ok(input logic [WORD_BITS-1:0] w,
                                   input logic [GEN_BITS-1:0] gen);
    return mark_ok(w) && (w[PAYLOAD_BITS +: GEN_BITS] == gen);
  endfunction

  // Assembles a packet word from a generation and a payload.
  function automatic logic [WORD_BITS-1:0] make_packet(input logic [GEN_BITS-1:0] gen,
                                                       input logic [9:0] payload);
    return MARK_VALUE | (WORD_BITS'(gen) << PAYLOAD_BITS) | (WORD_BITS'(payload) & PAY_MASK);
  endfunction

endpackage

[hw/rtl/llx_if.sv]
// Valid/ready channel interfaces for the input events and the result items.
interface llx_in_if import llx_pkg::*; (input logic clk);
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (input clk, output valid, output data, input ready);
  modport sink   (input clk, input valid, input data, output ready);
endinterface

interface llx_out_if import llx_pkg::*; (input logic clk);
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (input clk, output valid, output data, input ready);
  modport sink   (input clk, input valid, input data, output ready);
endinterface

[hw/rtl/llx_step.sv]
// Event logic: next exchange state and the result item for one event.
module llx_step import llx_pkg::*; (
  input  in_item_t  item,
  input  state_t    st,
  input  cfg_t      cfg,
  output state_t    st_nxt,
  output out_item_t res
);

  logic [15:0]         e_lo;
  logic [9:0]          e_clamp;
  logic [GEN_BITS-1:0] gen_inc;
  logic [GEN_BITS-1:0] gen_dec;
  logic [9:0]          phase1_payload;
  logic [15:0]         waited;
  logic                behind;
  logic [15:0]         r0_ext;

  always_comb begin
    // Clamp below at one first, then above at the configured maximum.
    e_lo    = (item.elapsed < 16'sd1) ? 16'd1 : 16'(item.elapsed);
    e_clamp = (e_lo > 16'(cfg.elapsed_max)) ? cfg.elapsed_max : e_lo[9:0];
    gen_inc = st.generation + GEN_BITS'(1);
    gen_dec = st.generation - GEN_BITS'(1);
    phase1_payload = (item.player_id == 2'd0) ? st.held_elapsed : 10'd0;
    waited  = item.timer_now - st.wait_start;
    behind  = st.have_previous && mark_ok(item.word_b) &&
              (item.word_b[PAYLOAD_BITS +: GEN_BITS] == gen_dec);
    r0_ext  = 16'(st.recv_p0);

    st_nxt = st;
    res    = '0;

    case (cmd_e'(item.command))
      CMD_STEP: begin
        st_nxt.held_elapsed = e_clamp;
        st_nxt.wait_start   = item.timer_now;
        if (!st.tx_pending) begin
          st_nxt.current_packet = make_packet(st.generation,
                                              st.step_phase ? ((item.player_id == 2'd0) ?
                                              e_clamp : 10'd0) : item.buttons);
          st_nxt.tx_pending = 1'b1;
          res.send_valid    = 1'b1;
          res.send_word     = st_nxt.current_packet;
        end
      end
      CMD_RECV: begin
        if (!item.sio_error && word_ok(item.word_a, st.generation) &&
            word_ok(item.word_b, st.generation)) begin
          st_nxt.recv_p0  = item.word_a[PAYLOAD_BITS-1:0];
          st_nxt.recv_p1  = item.word_b[PAYLOAD_BITS-1:0];
          st_nxt.rx_ready = 1'b1;
        end
      end
      CMD_POLL: begin
        if (st.tx_pending) begin
          if (st.rx_ready) begin
            st_nxt.previous_packet = st.current_packet;
            st_nxt.have_previous   = 1'b1;
            st_nxt.rx_ready        = 1'b0;
            st_nxt.generation      = gen_inc;
            st_nxt.tx_pending      = 1'b0;
            if (!st.step_phase) begin
              // Buttons agreed; the elapsed exchange starts right away.
              st_nxt.agreed_p0      = BTN_BITS'(st.recv_p0);
              st_nxt.agreed_p1      = BTN_BITS'(st.recv_p1);
              st_nxt.step_phase     = 1'b1;
              st_nxt.current_packet = make_packet(gen_inc, phase1_payload);
              st_nxt.tx_pending     = 1'b1;
              st_nxt.wait_start     = item.timer_now;
              res.send_valid        = 1'b1;
              res.send_word         = st_nxt.current_packet;
            end else begin
              st_nxt.step_phase   = 1'b0;
              res.status          = ST_STEP_DONE;
              res.buttons_player0 = st.agreed_p0;
              res.buttons_player1 = st.agreed_p1;
              res.agreed_elapsed  = (r0_ext != 16'd0 && r0_ext <= 16'(cfg.elapsed_max)) ?
                                    10'(st.recv_p0) : 10'd1;
            end
          end else if (!item.connected || item.player_id > 2'd1) begin
            res.status = ST_LINK_LOST;
          end else begin
            if (!item.is_slave && !item.transfer_busy) begin
              res.send_valid     = 1'b1;
              res.send_word      = behind ? st.previous_packet : st.current_packet;
              res.start_transfer = 1'b1;
            end
            if (waited > cfg.timeout_ticks) begin
              res.status = ST_TIMED_OUT;
            end
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

[hw/rtl/llx_out_buf.sv]
// Two-entry result buffer that drives the output channel.
module llx_out_buf import llx_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  out_item_t     push_data,
  output logic          push_ready,
  llx_out_if.source     out_ch
);

  out_item_t head_r;
  out_item_t tail_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign pop          = out_ch.valid && out_ch.ready;
  assign push_ready   = (cnt_r != 2'd2);
  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.data  = head_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      head_r <= push_data;
    end else if (pop) begin
      head_r <= tail_r;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        head_r <= push_data;
      end else begin
        tail_r <= push_data;
      end
    end
  end

endmodule

[hw/rtl/lockstep_link_exchange_core.sv]
// Top level of the lockstep link exchange: input register, event logic and result buffer.
//
// The block runs a two-player lockstep input exchange over a multiplayer serial link. Every
// transaction on the input channel is one event (step request, receive complete or poll tick)
// and produces exactly one result transaction on the output channel. The block sustains one
// event per clock cycle while the output buffer has room: an event is captured in the input
// register, its effect on the exchange state and its result are computed in the following
// cycle by the event logic, and the result is written into a two-entry output buffer whose
// head drives the output channel. The two-entry buffer lets the input side keep taking
// events while one finished result waits for the consumer; input ready drops only when both
// buffer entries are full and an event is already held in the input register. Configuration
// writes (timeout ticks at index 0, elapsed maximum at index 1) take effect on the next
// cycle and should be made while no event is in flight.
module lockstep_link_exchange_core import llx_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  llx_in_if.sink                   in_ch,
  llx_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // Configuration registers.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
      cfg_r.elapsed_max   <= ELAPSED_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data[15:0];
        CFG_ELAPSED_MAX:   cfg_r.elapsed_max   <= cfg_data[9:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Input register. It refills in the same cycle its event moves on.
  in_item_t in_item_r;
  logic     in_valid_r;
  logic     in_valid_nxt;
  logic     in_take;
  logic     fire;
  logic     buf_ready;

  assign fire        = in_valid_r && buf_ready;
  assign in_ch.ready = !in_valid_r || buf_ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_ch.data;
    end
  end

  // Exchange state. Packet and payload holders are not reset: they are always written
  // before anything reads them.
  state_t    state_r;
  state_t    state_nxt;
  out_item_t result;

  llx_step u_step (
    .item   (in_item_r),
    .st     (state_r),
    .cfg    (cfg_r),
    .st_nxt (state_nxt),
    .res    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.generation    <= '0;
      state_r.rx_ready      <= 1'b0;
      state_r.tx_pending    <= 1'b0;
      state_r.step_phase    <= 1'b0;
      state_r.have_previous <= 1'b0;
      state_r.wait_start    <= 16'd0;
      state_r.held_elapsed  <= 10'd1;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Result buffer feeding the output channel.
  llx_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_data  (result),
    .push_ready (buf_ready),
    .out_ch     (out_ch)
  );

endmodule

[dv/testbench.sv]
// Self-checking testbench for the lockstep link exchange core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import llx_pkg::*;

  // Command encoding 3 is not used by the block; it must come back as an all-zero result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Top three bits of every packet word: the marker bit set, the rest clear.
  localparam logic [2:0] MARKER = 3'b100;
  // A result leaves the block through the input register and the output buffer; this leaves some margin on top.
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_SETTING = 100;
  localparam int NUM_SETTINGS = 6;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  llx_in_if  in_ch  (.clk(clk));
  llx_out_if out_ch (.clk(clk));

  lockstep_link_exchange_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the exchange state, advanced once per accepted event transaction.
  logic [2:0]  gen_q;
  logic        rx_rdy;
  logic        tx_pend;
  logic        phase;
  logic        have_prev;
  logic [15:0] cur_pkt;
  logic [15:0] prev_pkt;
  logic [9:0]  rcv_p0, rcv_p1;
  logic [9:0]  agr_p0, agr_p1;
  logic [15:0] wait_t0;
  logic [9:0]  held_el;
  logic [15:0] timeout_cfg;
  logic [9:0]  emax_cfg;

  out_item_t results_due[$];
  int        mismatches = 0;
  int        sent_count = 0;
  int        burst_left = 0;

  // Directed script: an event plus, where the answer is obvious, the result typed in by hand.
  typedef struct {
    in_item_t  ev;
    bit        typed;
    out_item_t res;
  } script_row_t;

  script_row_t script[$];

  function automatic logic [15:0] pack_word(input logic [9:0] payload);
    return {MARKER, gen_q, payload};
  endfunction

  function automatic logic good_word(input logic [15:0] w);
    return w[15:13] == MARKER && w[12:10] == gen_q;
  endfunction

  // Computes the result of one event and moves the shadow state forward.
  function automatic out_item_t exchange_predict(input in_item_t ev);
    out_item_t   r;
    int          e;
    logic [15:0] waited;
    logic        behind;
    r = '0;
    case (ev.command)
      CMD_STEP: begin
        // Clamp to one first, then to the maximum.
        e = $signed(ev.elapsed);
        if (e < 1) e = 1;
        if (e > int'(emax_cfg)) e = int'(emax_cfg);
        held_el = e[9:0];
        if (!tx_pend) begin
          cur_pkt = pack_word(phase ? (ev.player_id == 2'd0 ? held_el : 10'd0) : ev.buttons);
          tx_pend = 1'b1;
          r.send_valid = 1'b1;
          r.send_word = cur_pkt;
        end
        wait_t0 = ev.timer_now;
      end
      CMD_RECV: begin
        if (!ev.sio_error && good_word(ev.word_a) && good_word(ev.word_b)) begin
          rcv_p0 = ev.word_a[9:0];
          rcv_p1 = ev.word_b[9:0];
          rx_rdy = 1'b1;
        end
      end
      CMD_POLL: begin
        if (tx_pend) begin
          if (rx_rdy) begin
            prev_pkt = cur_pkt;
            have_prev = 1'b1;
            rx_rdy = 1'b0;
            gen_q = gen_q + 3'd1;
            tx_pend = 1'b0;
            if (!phase) begin
              // Buttons agreed; the elapsed count goes out next under the new generation.
              agr_p0 = rcv_p0;
              agr_p1 = rcv_p1;
              phase = 1'b1;
              cur_pkt = pack_word(ev.player_id == 2'd0 ? held_el : 10'd0);
              tx_pend = 1'b1;
              r.send_valid = 1'b1;
              r.send_word = cur_pkt;
              wait_t0 = ev.timer_now;
            end else begin
              r.buttons_player0 = agr_p0;
              r.buttons_player1 = agr_p1;
              r.agreed_elapsed = (rcv_p0 != 10'd0 && rcv_p0 <= emax_cfg) ? rcv_p0 : 10'd1;
              phase = 1'b0;
              r.status = ST_STEP_DONE;
            end
          end else if (!ev.connected || ev.player_id > 2'd1) begin
            r.status = ST_LINK_LOST;
          end else begin
            if (!ev.is_slave && !ev.transfer_busy) begin
              // The peer still shows the previous generation: it missed our last packet.
              behind = have_prev && ev.word_b[15:13] == MARKER &&
                       ev.word_b[12:10] == gen_q - 3'd1;
              r.send_word = behind ? prev_pkt : cur_pkt;
              r.send_valid = 1'b1;
              r.start_transfer = 1'b1;
            end
            waited = ev.timer_now - wait_t0;
            if (waited > timeout_cfg) r.status = ST_TIMED_OUT;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t ev_of(input logic [1:0] cmd, input logic [9:0] btn,
                                     input logic [15:0] el, input logic [15:0] wa,
                                     input logic [15:0] wb, input logic err, conn, slave, busy,
                                     input logic [1:0] pid, input logic [15:0] now);
    in_item_t ev;
    ev.command = cmd;
    ev.buttons = btn;
    ev.elapsed = el;
    ev.word_a = wa;
    ev.word_b = wb;
    ev.sio_error = err;
    ev.connected = conn;
    ev.is_slave = slave;
    ev.transfer_busy = busy;
    ev.player_id = pid;
    ev.timer_now = now;
    return ev;
  endfunction

  function automatic out_item_t result_of(input status_e st, input logic sv,
                                          input logic [15:0] sw);
    out_item_t r;
    r = '0;
    r.status = st;
    r.send_valid = sv;
    r.send_word = sw;
    return r;
  endfunction

  task automatic add_row(input in_item_t ev, input bit typed, input out_item_t res);
    script_row_t row;
    row.ev = ev;
    row.typed = typed;
    row.res = res;
    script.push_back(row);
  endtask

  // Every field fully random, so that every input bit toggles.
  function automatic in_item_t noise_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [15:0] pick_elapsed();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom());
      1:       return 16'($urandom_range(0, 20));
      2:       return 16'(int'(emax_cfg) + int'($urandom_range(0, 4)) - 2);
      default: return 16'($urandom_range(1, emax_cfg));
    endcase
  endfunction

  // A poll that is mostly connected and legal, with a timer spread around the timeout limit.
  function automatic in_item_t poll_item();
    in_item_t ev;
    ev = noise_item();
    ev.command = CMD_POLL;
    ev.connected = $urandom_range(0, 7) != 0;
    ev.player_id = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3))
                                               : 2'($urandom_range(0, 1));
    ev.is_slave = $urandom_range(0, 3) == 0;
    ev.transfer_busy = $urandom_range(0, 3) == 0;
    if ($urandom_range(0, 1) == 1) ev.word_b = {MARKER, gen_q - 3'd1, 10'($urandom())};
    case ($urandom_range(0, 3))
      0:       ev.timer_now = wait_t0 + 16'($urandom_range(0, timeout_cfg));
      1:       ev.timer_now = wait_t0 + timeout_cfg + 16'($urandom_range(0, 3));
      2:       ev.timer_now = 16'($urandom());
      default: ev.timer_now = wait_t0 + 16'($urandom_range(0, 8));
    endcase
    return ev;
  endfunction

  // A word pair for the current generation; about one in four is spoiled on purpose.
  function automatic in_item_t recv_item();
    in_item_t    ev;
    logic [9:0]  pay;
    ev = noise_item();
    ev.command = CMD_RECV;
    ev.sio_error = 1'b0;
    pay = 10'($urandom());
    if (phase) begin
      case ($urandom_range(0, 2))
        0:       pay = 10'($urandom_range(1, emax_cfg));
        1:       pay = 10'd0;
        default: ;
      endcase
    end
    ev.word_a = pack_word(pay);
    ev.word_b = pack_word(10'($urandom()));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       ev.sio_error = 1'b1;
        1:       ev.word_a[12:10] = gen_q ^ 3'($urandom_range(1, 7));
        2:       ev.word_b[15:13] = MARKER ^ 3'($urandom_range(1, 7));
        default: ev.word_a[15:13] = MARKER ^ 3'($urandom_range(1, 7));
      endcase
    end
    return ev;
  endfunction

  // Offers one event transaction, in bursts separated by random gaps, and records its result.
  task automatic deliver(input in_item_t ev, input bit typed, input out_item_t typed_res);
    int        gap;
    out_item_t predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= ev;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = exchange_predict(ev);
    results_due.push_back(typed ? typed_res : predicted);
    sent_count++;
  endtask

  // One full game step: a step request, then two exchanges, with waiting polls and
  // spoiled receives mixed in.
  task automatic play_round();
    in_item_t ev;
    ev = noise_item();
    ev.command = CMD_STEP;
    ev.elapsed = pick_elapsed();
    ev.player_id = ($urandom_range(0, 3) == 0) ? 2'd1 : 2'd0;
    deliver(ev, 1'b0, '0);
    for (int half = 0; half < 2; half++) begin
      repeat ($urandom_range(0, 3)) deliver(poll_item(), 1'b0, '0);
      repeat ($urandom_range(1, 2)) deliver(recv_item(), 1'b0, '0);
      deliver(poll_item(), 1'b0, '0);
    end
  endtask

  // Stop offering events and wait until every outstanding result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // Both registers go in on back-to-back edges; the block is idle at this point.
  task automatic write_config(input logic [15:0] tmo, input logic [9:0] emax);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data  <= tmo;
    @(posedge clk);
    timeout_cfg = tmo;
    cfg_index <= CFG_ELAPSED_MAX;
    cfg_data  <= 16'(emax);
    @(posedge clk);
    emax_cfg = emax;
    cfg_we <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // The receiver picks a new stall habit whenever its random countdown runs out: always ready,
  // coin flip, mostly stalled, or stalled while the low four bits of the countdown are below twelve.
  int stall_left = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= 1'($urandom_range(0, 1));
      2:       out_ch.ready <= $urandom_range(0, 3) == 0;
      default: out_ch.ready <= stall_left[3:0] >= 4'd12;
    endcase
  end

  // Every result transaction is matched in order against the oldest outstanding expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("result transaction with nothing outstanding: 0x%0h", out_ch.data);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("status", 16'(want.status), 16'(out_ch.data.status));
        check_field("send_valid", 16'(want.send_valid), 16'(out_ch.data.send_valid));
        check_field("send_word", want.send_word, out_ch.data.send_word);
        check_field("start_transfer", 16'(want.start_transfer),
                    16'(out_ch.data.start_transfer));
        check_field("buttons_player0", 16'(want.buttons_player0),
                    16'(out_ch.data.buttons_player0));
        check_field("buttons_player1", 16'(want.buttons_player1),
                    16'(out_ch.data.buttons_player1));
        check_field("agreed_elapsed", 16'(want.agreed_elapsed),
                    16'(out_ch.data.agreed_elapsed));
      end
    end
  end

  initial begin
    out_item_t idle_res;
    in_item_t  ev;
    logic [15:0] tmo;
    logic [9:0]  emax;
    int          first;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_TIMEOUT_TICKS;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;

    gen_q = '0;
    rx_rdy = 1'b0;
    tx_pend = 1'b0;
    phase = 1'b0;
    have_prev = 1'b0;
    cur_pkt = '0;
    prev_pkt = '0;
    rcv_p0 = '0;
    rcv_p1 = '0;
    agr_p0 = '0;
    agr_p1 = '0;
    wait_t0 = '0;
    held_el = 10'd1;
    timeout_cfg = TIMEOUT_RESET;
    emax_cfg = ELAPSED_MAX_RESET;

    idle_res = result_of(ST_WAITING, 1'b0, 16'h0000);

    // Directed script under the reset configuration (timeout 1638, elapsed maximum 15).
    // The unused command and an idle poll do nothing; a receive never reports anything.
    add_row(ev_of(CMD_UNUSED, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 1, 2'd3,
                  16'hFFFF), 1'b1, idle_res);
    add_row(ev_of(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 2'd3, 0), 1'b1, idle_res);
    add_row(ev_of(CMD_RECV, 0, 0, 16'h8000, 16'h83FF, 1, 1, 0, 0, 0, 0), 1'b1, idle_res);
    // Step request with the most negative elapsed count sends the button packet at once.
    add_row(ev_of(CMD_STEP, 10'h3FF, 16'h8000, 0, 0, 0, 1, 0, 0, 0, 16'd100), 1'b1,
            result_of(ST_WAITING, 1'b1, 16'h83FF));
    // A second request while a packet is pending keeps the packet; elapsed clamps high.
    add_row(ev_of(CMD_STEP, 0, 16'h7FFF, 0, 0, 0, 1, 0, 0, 2'd2, 16'd200), 1'b1, idle_res);
    // Link loss: disconnected, then a player id above one.
    add_row(ev_of(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd210), 1'b1,
            result_of(ST_LINK_LOST, 1'b0, 16'h0000));
    add_row(ev_of(CMD_POLL, 0, 0, 0, 0, 0, 1, 0, 0, 2'd3, 16'd210), 1'b1,
            result_of(ST_LINK_LOST, 1'b0, 16'h0000));
    // Master reload one tick past the timeout, a slave just inside it, and a wrapped timer.
    add_row(ev_of(CMD_POLL, 0, 0, 0, 0, 0, 1, 0, 0, 2'd1, 16'd1839), 1'b0, idle_res);
    add_row(ev_of(CMD_POLL, 0, 0, 0, 0, 0, 1, 1, 1, 2'd1, 16'd1838), 1'b0, idle_res);
    add_row(ev_of(CMD_POLL, 0, 0, 0, 0, 0, 1, 0, 1, 0, 16'd150), 1'b0, idle_res);
    // Receives with a bad marker or a wrong generation are dropped.
    add_row(ev_of(CMD_RECV, 0, 0, 16'hC155, 16'h82AA, 0, 1, 0, 0, 0, 0), 1'b0, idle_res);
    add_row(ev_of(CMD_RECV, 0, 0, 16'h8555, 16'h82AA, 0, 1, 0, 0, 0, 0), 1'b0, idle_res);
    add_row(ev_of(CMD_RECV, 0, 0, 16'h8155, 16'h02AA, 0, 1, 0, 0, 0, 0), 1'b0, idle_res);
    // A valid pair, then a later valid pair that overwrites it.
    add_row(ev_of(CMD_RECV, 0, 0, 16'h8155, 16'h82AA, 0, 1, 0, 0, 0, 0), 1'b0, idle_res);
    add_row(ev_of(CMD_RECV, 0, 0, 16'h83FF, 16'h8000, 0, 1, 0, 0, 0, 0), 1'b0, idle_res);
    // First exchange finishes, then the peer is one generation behind and gets a re-send.
    add_row(ev_of(CMD_POLL, 0, 0, 0, 0, 0, 1, 0, 0, 0, 16'd300), 1'b0, idle_res);
    add_row(ev_of(CMD_POLL, 0, 0, 0, 16'h8123, 0, 1, 0, 0, 0, 16'd310), 1'b0, idle_res);
    // Elapsed of zero from the peer is invalid and is agreed as one.
    add_row(ev_of(CMD_RECV, 0, 0, 16'h8400, 16'h8400, 0, 1, 0, 0, 0, 0), 1'b0, idle_res);
    add_row(ev_of(CMD_POLL, 0, 0, 0, 0, 0, 1, 0, 0, 0, 16'd320), 1'b0, idle_res);
    // A pair already latched before the step request: completion still waits for a poll.
    add_row(ev_of(CMD_RECV, 0, 0, 16'h8801, 16'h8BFE, 0, 1, 0, 0, 0, 0), 1'b0, idle_res);
    add_row(ev_of(CMD_STEP, 10'h2AA, 16'h0000, 0, 0, 0, 1, 0, 0, 2'd1, 16'd400), 1'b0,
            idle_res);
    // Player one sends zero as its elapsed count.
    add_row(ev_of(CMD_POLL, 0, 0, 0, 0, 0, 1, 0, 0, 2'd1, 16'd410), 1'b0, idle_res);
    add_row(ev_of(CMD_RECV, 0, 0, 16'h8C0F, 16'h8C00, 0, 1, 0, 0, 0, 0), 1'b0, idle_res);
    add_row(ev_of(CMD_POLL, 0, 0, 0, 0, 0, 1, 0, 0, 0, 16'd420), 1'b0, idle_res);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) deliver(script[i].ev, script[i].typed, script[i].res);
    // The sender holds off here until every outstanding result has arrived.
    drain_results();

    // Random part: several register settings, the extremes among them, each with a batch
    // of mostly well-formed game steps and some pure noise.
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: begin tmo = 16'd0;     emax = 10'd1;    end
        1: begin tmo = 16'hFFFF;  emax = 10'd1023; end
        2: begin tmo = 16'($urandom()); emax = 10'($urandom_range(1, 1023)); end
        3: begin tmo = 16'd40;    emax = 10'd3;    end
        4: begin tmo = 16'($urandom_range(0, 200)); emax = 10'($urandom_range(1, 30)); end
        default: begin tmo = TIMEOUT_RESET; emax = ELAPSED_MAX_RESET; end
      endcase
      write_config(tmo, emax);
      first = sent_count;
      while (sent_count - first < ITEMS_PER_SETTING) begin
        if ($urandom_range(0, 9) < 7) begin
          play_round();
        end else begin
          ev = noise_item();
          deliver(ev, 1'b0, idle_res);
        end
      end
      drain_results();
    end

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
